FILE: hdl/apsum_pkg.sv
package apsum_pkg;

   // Field widths fixed by the channel definitions.
   localparam int PAGE_W  = 8;
   localparam int DIST_W  = 8;
   localparam int TOTAL_W = 21;
   localparam int COUNT_W = 15;

   // Default size of the distance store, in nodes per side.
   localparam int MAX_NODES_DEFAULT = 128;

   // Hop count that marks an unreachable pair.
   localparam logic [DIST_W-1:0] UNREACH = '1;
   localparam logic [DIST_W-1:0] DIST_ZERO = '0;
   localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1);

   // Function codes of the request channel.
   localparam logic FUNC_LINK    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic cnt_clear;
      logic acc_clear;
      logic clr_step;
      logic link_wr;
      logic node_clear;
      logic row_read;
      logic row_load;
      logic elem_read;
      logic elem_write;
      logic sum_read;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_compute;
      logic n_zero;
      logic j_last;
      logic i_last;
      logic k_last;
      logic clr_last;
   } status_type;

endpackage

FILE: hdl/apsum_if.sv
// Request channel: one link or one compute command per transaction.
interface apsum_req_if;
   logic                            valid;
   logic                            ready;
   logic                            func;
   logic [apsum_pkg::PAGE_W-1:0]    from_page;
   logic [apsum_pkg::PAGE_W-1:0]    to_page;

   modport source(output valid, func, from_page, to_page, input ready);
   modport sink(input valid, func, from_page, to_page, output ready);
endinterface

// Response channel: one report per compute transaction.
interface apsum_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [apsum_pkg::TOTAL_W-1:0]   total_hops;
   logic [apsum_pkg::COUNT_W-1:0]   pair_count;

   modport source(output valid, total_hops, pair_count, input ready);
   modport sink(input valid, total_hops, pair_count, output ready);
endinterface

FILE: hdl/apsum_ram.sv
// Generic RAM with one write port and two registered read ports.
module apsum_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: hdl/apsum_dp.sv
// Datapath: loop counters, distance store, relaxation and accumulation.
module apsum_dp #(
   parameter int MAX_NODES = apsum_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  apsum_pkg::cmd_type            cmd,
   output apsum_pkg::status_type         status,
   input  logic                          req_func,
   input  logic [apsum_pkg::PAGE_W-1:0]  req_from_page,
   input  logic [apsum_pkg::PAGE_W-1:0]  req_to_page,
   output logic [apsum_pkg::TOTAL_W-1:0] rsp_total_hops,
   output logic [apsum_pkg::COUNT_W-1:0] rsp_pair_count
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DEPTH = MAX_NODES * MAX_NODES;
   localparam int AW = $clog2(DEPTH);
   localparam int PW = apsum_pkg::PAGE_W;
   localparam int DW = apsum_pkg::DIST_W;
   localparam int TW = apsum_pkg::TOTAL_W;
   localparam int CW = apsum_pkg::COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);
   localparam logic [PW-1:0] MAX_PAGE = PW'(MAX_NODES);
   localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_NODES);

   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [PW-1:0]    node_count_ff, node_count_in;
   logic [DW-1:0]    dik_ff, dik_in;
   logic             acc_valid_ff, acc_valid_in;
   logic [TW-1:0]    total_ff, total_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [TW-1:0]    out_total_ff, out_total_in;
   logic [CW-1:0]    out_count_ff, out_count_in;

   logic [PW-1:0]    n_m1;
   logic             j_end, i_end, advance;
   logic             link_ok;
   logic [PW-1:0]    from_m1, to_m1;
   logic [AW-1:0]    addr_ij, addr_ik, addr_kj, addr_link;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [DW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr_a;
   logic [DW-1:0]    rd_data_a, rd_data_b;
   logic [DW:0]      cand_wide;
   logic [DW-1:0]    cand;
   logic             relax_wr;
   logic             dist_counts;
   logic [TW:0]      total_sum;
   logic [CW:0]      count_sum;

   // Loop bounds and status toward the controller.
   assign n_m1 = node_count_ff - PW'(1);
   always_comb begin
      status.req_compute = (req_func == apsum_pkg::FUNC_COMPUTE);
      status.n_zero      = (node_count_ff == '0);
      status.j_last      = (PW'(j_ff) == n_m1);
      status.i_last      = (PW'(i_ff) == n_m1);
      status.k_last      = (PW'(k_ff) == n_m1);
      status.clr_last    = (i_ff == LAST_IDX) && (j_ff == LAST_IDX);
   end

   // Counter stepping: the clearing sweep covers the whole store, the rest only n by n.
   assign j_end   = cmd.clr_step ? (j_ff == LAST_IDX) : status.j_last;
   assign i_end   = cmd.clr_step ? (i_ff == LAST_IDX) : status.i_last;
   assign advance = cmd.clr_step | cmd.elem_write | cmd.sum_read;

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (cmd.cnt_clear) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (advance) begin
         if (j_end) begin
            j_in = '0;
            if (i_end) begin
               i_in = '0;
               if (cmd.elem_write) begin
                  k_in = k_ff + IDX_W'(1);
               end
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end

   // Link range check and the highest page seen.
   assign link_ok = (req_from_page != '0) && (req_from_page <= MAX_PAGE) &&
                    (req_to_page != '0) && (req_to_page <= MAX_PAGE);
   assign from_m1 = req_from_page - PW'(1);
   assign to_m1   = req_to_page - PW'(1);

   always_comb begin
      node_count_in = node_count_ff;
      if (cmd.node_clear) begin
         node_count_in = '0;
      end else if (cmd.link_wr && link_ok) begin
         if (req_from_page > node_count_in) begin
            node_count_in = req_from_page;
         end
         if (req_to_page > node_count_in) begin
            node_count_in = req_to_page;
         end
      end
   end

   // Store addresses, row major.
   assign addr_ij   = AW'(i_ff) * ROW_STRIDE + AW'(j_ff);
   assign addr_ik   = AW'(i_ff) * ROW_STRIDE + AW'(k_ff);
   assign addr_kj   = AW'(k_ff) * ROW_STRIDE + AW'(j_ff);
   assign addr_link = AW'(from_m1[IDX_W-1:0]) * ROW_STRIDE + AW'(to_m1[IDX_W-1:0]);
   assign rd_addr_a = cmd.elem_read ? addr_kj : addr_ik;

   // Relaxation: port A holds d[k][j], port B holds d[i][j].
   assign cand_wide = {1'b0, dik_ff} + {1'b0, rd_data_a};
   assign cand      = cand_wide[DW] ? apsum_pkg::UNREACH : cand_wide[DW-1:0];
   assign relax_wr  = cmd.elem_write && (cand < rd_data_b);
   assign dik_in    = cmd.row_load ? rd_data_a : dik_ff;

   // Write port shared by the clearing sweep, link loads and relaxation.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ij;
      wr_data = cand;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_data = (i_ff == j_ff) ? apsum_pkg::DIST_ZERO : apsum_pkg::UNREACH;
      end else if (cmd.link_wr) begin
         wr_en   = link_ok;
         wr_addr = addr_link;
         wr_data = apsum_pkg::DIST_ONE;
      end else if (relax_wr) begin
         wr_en   = 1'b1;
      end
   end

   apsum_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(addr_ij),
      .rd_data_b(rd_data_b)
   );

   // Saturating accumulation, in the cycle after each sum read.
   assign acc_valid_in = cmd.sum_read;
   assign dist_counts  = acc_valid_ff && (rd_data_b != apsum_pkg::UNREACH) &&
                         (rd_data_b != apsum_pkg::DIST_ZERO);
   assign total_sum    = {1'b0, total_ff} + (TW + 1)'(rd_data_b);
   assign count_sum    = {1'b0, count_ff} + (CW + 1)'(1);

   always_comb begin
      total_in = total_ff;
      count_in = count_ff;
      if (cmd.acc_clear) begin
         total_in = '0;
         count_in = '0;
      end else if (dist_counts) begin
         total_in = total_sum[TW] ? '1 : total_sum[TW-1:0];
         count_in = count_sum[CW] ? '1 : count_sum[CW-1:0];
      end
   end

   // Output register of the response payload.
   assign out_total_in = cmd.out_load ? total_ff : out_total_ff;
   assign out_count_in = cmd.out_load ? count_ff : out_count_ff;
   assign rsp_total_hops = out_total_ff;
   assign rsp_pair_count = out_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         node_count_ff <= '0;
         acc_valid_ff  <= 1'b0;
      end else begin
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         node_count_ff <= node_count_in;
         acc_valid_ff  <= acc_valid_in;
      end
      dik_ff       <= dik_in;
      total_ff     <= total_in;
      count_ff     <= count_in;
      out_total_ff <= out_total_in;
      out_count_ff <= out_count_in;
   end

endmodule

FILE: hdl/apsum_ctrl.sv
// Controller: sequences clearing, link loads, relaxation, summing and the report.
module apsum_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  apsum_pkg::status_type status,
   output apsum_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR      = 9'b000000001,
      ST_IDLE       = 9'b000000010,
      ST_ROW_READ   = 9'b000000100,
      ST_ROW_LOAD   = 9'b000001000,
      ST_ELEM_READ  = 9'b000010000,
      ST_ELEM_WRITE = 9'b000100000,
      ST_SUM        = 9'b001000000,
      ST_SUM_FLUSH  = 9'b010000000,
      ST_DONE       = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.req_compute) begin
                  cmd.cnt_clear = 1'b1;
                  cmd.acc_clear = 1'b1;
                  state_in      = status.n_zero ? ST_DONE : ST_ROW_READ;
               end else begin
                  cmd.link_wr = 1'b1;
               end
            end
         end
         ST_ROW_READ: begin
            cmd.row_read = 1'b1;
            state_in     = ST_ROW_LOAD;
         end
         ST_ROW_LOAD: begin
            cmd.row_load = 1'b1;
            state_in     = ST_ELEM_READ;
         end
         ST_ELEM_READ: begin
            cmd.elem_read = 1'b1;
            state_in      = ST_ELEM_WRITE;
         end
         ST_ELEM_WRITE: begin
            cmd.elem_write = 1'b1;
            if (status.j_last) begin
               if (status.i_last && status.k_last) begin
                  cmd.cnt_clear = 1'b1;
                  state_in      = ST_SUM;
               end else begin
                  state_in = ST_ROW_READ;
               end
            end else begin
               state_in = ST_ELEM_READ;
            end
         end
         ST_SUM: begin
            cmd.sum_read = 1'b1;
            if (status.j_last && status.i_last) begin
               state_in = ST_SUM_FLUSH;
            end
         end
         ST_SUM_FLUSH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.node_clear = 1'b1;
               cmd.cnt_clear  = 1'b1;
               state_in       = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Response valid flag of the output register.
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/all_pairs_hop_distance_sum_core.sv
// All-pairs hop distance sum.
//
// The req channel carries one transaction per command. With func at zero it
// adds a unit-weight directed link from_page to to_page (pages 1 to
// MAX_NODES, others are ignored). With func at one the block runs
// shortest-path relaxation over pages 1 to the highest page loaded, then
// reports on the rsp channel the sum of all finite nonzero hop counts and
// the number of such pairs, both saturating.
// A compute walks k, i and j over the n nodes: for each row it fetches the
// row operand d[i][k] (read, then load), and each element update is a read
// and a write on the distance RAM; then comes one summing read per pair, a
// flush of the sum and the load of the output register. An empty store goes
// straight to the report.
// After each report, and after reset, the store is swept back to its initial
// contents, one entry a cycle, MAX_NODES^2 entries (16384 at the default);
// req is not ready during that sweep. Reset is synchronous and active high.
// The report sits in an output register: the sweep and further link
// transactions proceed while the receiver stalls, and only a following
// report waits until the pending one has been taken.
module all_pairs_hop_distance_sum_core #(
   parameter int MAX_NODES = apsum_pkg::MAX_NODES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   apsum_req_if.sink   req_ch,
   apsum_rsp_if.source rsp_ch
);

   apsum_pkg::cmd_type    cmd;
   apsum_pkg::status_type status;

   apsum_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   apsum_dp #(
      .MAX_NODES(MAX_NODES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_func      (req_ch.func),
      .req_from_page (req_ch.from_page),
      .req_to_page   (req_ch.to_page),
      .rsp_total_hops(rsp_ch.total_hops),
      .rsp_pair_count(rsp_ch.pair_count)
   );

   // Only one source drives the store's write port in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.link_wr, cmd.elem_write}))
      else $error("store write sources overlap");

   // A new report never overwrites one the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("pending report overwritten");

   // The row operand is captured the cycle after it was read.
   assert property (@(posedge clock) disable iff (reset)
      cmd.row_load |-> $past(cmd.row_read))
      else $error("row operand loaded without a read");

   // Each relaxation write follows the read of its operands.
   assert property (@(posedge clock) disable iff (reset)
      cmd.elem_write |-> $past(cmd.elem_read))
      else $error("relaxation write without operand read");

   // No transaction is taken while the store is swept.
   assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_ch.ready)
      else $error("request accepted during the clearing sweep");

endmodule

FILE: sim/all_pairs_hop_distance_sum_core_tb.sv
module all_pairs_hop_distance_sum_core_tb;

   localparam int NODES       = apsum_pkg::MAX_NODES_DEFAULT;
   localparam int ITEM_TARGET = 500;
   localparam int MIN_REPORTS = 40;
   localparam int PAGE_W      = apsum_pkg::PAGE_W;
   localparam int DIST_W      = apsum_pkg::DIST_W;
   localparam int TOTAL_W     = apsum_pkg::TOTAL_W;
   localparam int COUNT_W     = apsum_pkg::COUNT_W;
   // The sweep after the last report is the longest quiet stretch of the block.
   localparam int DRAIN_CYCLES = 2 * NODES * NODES + 100;
   // One full-size compute dominates the run; everything else is small.
   localparam longint CYCLE_LIMIT = 40_000_000;
   localparam logic [TOTAL_W-1:0] TOTAL_SAT = '1;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   typedef struct {
      logic [TOTAL_W-1:0] total_hops;
      logic [COUNT_W-1:0] pair_count;
   } hop_report_type;

   // Tracks the distance store and predicts the report of every compute.
   class hop_distance_tracker_type;
      logic [DIST_W-1:0] hop_dist [NODES][NODES];
      int unsigned       node_count;
      hop_report_type    expected_reports[$];
      int unsigned       mismatch_count;

      function new();
         mismatch_count = 0;
         clear_store();
      endfunction

      function void clear_store();
         for (int r = 0; r < NODES; r++) begin
            for (int c = 0; c < NODES; c++) begin
               hop_dist[r][c] = (r == c) ? apsum_pkg::DIST_ZERO : apsum_pkg::UNREACH;
            end
         end
         node_count = 0;
      endfunction

      function int unsigned pending();
         return expected_reports.size();
      endfunction

      // Applies one accepted transaction to the store.
      function void note_request(logic func, logic [PAGE_W-1:0] from_page,
                                 logic [PAGE_W-1:0] to_page);
         int unsigned       n;
         logic [DIST_W:0]   cand;
         logic [DIST_W-1:0] dik;
         longint unsigned   total;
         longint unsigned   count;
         hop_report_type    rep;
         if (func == apsum_pkg::FUNC_LINK) begin
            if (from_page >= 1 && from_page <= NODES && to_page >= 1 && to_page <= NODES) begin
               hop_dist[from_page - 1][to_page - 1] = apsum_pkg::DIST_ONE;
               if (32'(from_page) > node_count) node_count = 32'(from_page);
               if (32'(to_page) > node_count) node_count = 32'(to_page);
            end
            return;
         end
         n = (node_count > NODES) ? NODES : node_count;
         // Floyd-Warshall relaxation with saturating path sums.
         for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
               dik = hop_dist[i][k];
               for (int j = 0; j < n; j++) begin
                  cand = {1'b0, dik} + {1'b0, hop_dist[k][j]};
                  if (cand > {1'b0, apsum_pkg::UNREACH}) cand = {1'b0, apsum_pkg::UNREACH};
                  if (cand[DIST_W-1:0] < hop_dist[i][j] && !cand[DIST_W])
                     hop_dist[i][j] = cand[DIST_W-1:0];
               end
            end
         end
         // Sum the finite nonzero distances.
         total = 0;
         count = 0;
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               if (hop_dist[i][j] != apsum_pkg::UNREACH &&
                   hop_dist[i][j] != apsum_pkg::DIST_ZERO) begin
                  total += 64'(hop_dist[i][j]);
                  count += 1;
               end
            end
         end
         rep.total_hops = (total > TOTAL_SAT) ? TOTAL_SAT : total[TOTAL_W-1:0];
         rep.pair_count = (count > COUNT_SAT) ? COUNT_SAT : count[COUNT_W-1:0];
         expected_reports.push_back(rep);
         clear_store();
      endfunction

      // Compares one accepted report with the oldest prediction.
      function void check_report(logic [TOTAL_W-1:0] total_hops,
                                 logic [COUNT_W-1:0] pair_count);
         hop_report_type rep;
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected report: total_hops %0d pair_count %0d",
                        total_hops, pair_count);
            return;
         end
         rep = expected_reports.pop_front();
         if (total_hops !== rep.total_hops) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("total_hops mismatch: expected %0d got %0d",
                        rep.total_hops, total_hops);
         end
         if (pair_count !== rep.pair_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("pair_count mismatch: expected %0d got %0d",
                        rep.pair_count, pair_count);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   longint unsigned cycle_count = 0;

   apsum_req_if req_ch();
   apsum_rsp_if rsp_ch();

   all_pairs_hop_distance_sum_core #(.MAX_NODES(NODES)) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   hop_distance_tracker_type tracker = new();

   int unsigned burst_left = 0;
   int unsigned items_counted = 0;
   int unsigned computes_sent = 0;
   int unsigned ready_run = 0;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter for the watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: checks each report transaction and stalls in runs of random length.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         ready_run = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            tracker.check_report(rsp_ch.total_hops, rsp_ch.pair_count);
         if (ready_run == 0) begin
            if ($urandom_range(0, 3) != 0) begin
               rsp_ch.ready <= 1'b1;
               ready_run = $urandom_range(1, 64);
            end else begin
               rsp_ch.ready <= 1'b0;
               ready_run = $urandom_range(1, 40);
            end
         end else begin
            ready_run--;
         end
      end
   end

   // Sends one request transaction, opening a new burst after a random gap.
   task automatic send_request(logic func, logic [PAGE_W-1:0] from_page,
                               logic [PAGE_W-1:0] to_page);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= func;
      req_ch.from_page <= from_page;
      req_ch.to_page   <= to_page;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_request(func, from_page, to_page);
      burst_left--;
      if (func == apsum_pkg::FUNC_COMPUTE) begin
         items_counted++;
         computes_sent++;
      end else if (from_page >= 1 && from_page <= NODES && to_page >= 1 && to_page <= NODES) begin
         items_counted++;
      end
   endtask

   // A page number that the block must ignore.
   function automatic logic [PAGE_W-1:0] bad_page();
      return ($urandom_range(0, 3) == 0) ? PAGE_W'(0) : PAGE_W'($urandom_range(NODES + 1, 255));
   endfunction

   // One random graph over a few pages, usually followed by a compute.
   task automatic send_random_graph();
      int unsigned n;
      int unsigned links;
      int unsigned pick;
      logic [PAGE_W-1:0] p;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      links = $urandom_range(0, 2 * n);
      for (int l = 0; l < links; l++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            if ($urandom_range(0, 1) == 0)
               send_request(apsum_pkg::FUNC_LINK, bad_page(), PAGE_W'($urandom_range(0, 255)));
            else
               send_request(apsum_pkg::FUNC_LINK, PAGE_W'($urandom_range(0, 255)), bad_page());
         end else if (pick == 1) begin
            p = PAGE_W'($urandom_range(1, n));
            send_request(apsum_pkg::FUNC_LINK, p, p);
         end else begin
            send_request(apsum_pkg::FUNC_LINK, PAGE_W'($urandom_range(1, n)),
                         PAGE_W'($urandom_range(1, n)));
         end
      end
      // Now and then the graph runs on into the next one without a compute.
      if ($urandom_range(0, 19) != 0)
         send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'($urandom_range(0, 255)),
                      PAGE_W'($urandom_range(0, 255)));
   endtask

   // Main stimulus.
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= apsum_pkg::FUNC_LINK;
      req_ch.from_page <= '0;
      req_ch.to_page   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Compute on an empty store.
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(0), PAGE_W'(0));
      // A three-page cycle with a self link, a duplicate and ignored pages.
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(1), PAGE_W'(2));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(2), PAGE_W'(3));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(3), PAGE_W'(1));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(2), PAGE_W'(2));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(1), PAGE_W'(2));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(0), PAGE_W'(5));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(5), PAGE_W'(0));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(NODES + 1), PAGE_W'(1));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(1), PAGE_W'(255));
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(255), PAGE_W'(255));
      // A single self link.
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(1), PAGE_W'(1));
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(0), PAGE_W'(0));
      // The full-size store, reaching the highest page.
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(1), PAGE_W'(64));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(64), PAGE_W'(NODES));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(NODES), PAGE_W'(33));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(33), PAGE_W'(1));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(100), PAGE_W'(100));
      send_request(apsum_pkg::FUNC_LINK, PAGE_W'(NODES - 1), PAGE_W'(NODES));
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(128), PAGE_W'(127));
      // The store must be empty again after the report.
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(0), PAGE_W'(0));

      // Random graphs until enough items and reports have gone through.
      while (items_counted < ITEM_TARGET || computes_sent < MIN_REPORTS)
         send_random_graph();
      send_request(apsum_pkg::FUNC_COMPUTE, PAGE_W'(0), PAGE_W'(0));
      req_ch.valid <= 1'b0;

      // Wait for every report, then let the final sweep run out.
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
